FILE: rtl/core/glyph_blit_page_framebuffer_macros.svh
// Assertion macros shared by the glyph blit frame store RTL.
// Depends on nothing; included by modules that carry concurrent assertions.
`ifndef GLYPH_BLIT_PAGE_FRAMEBUFFER_MACROS_SVH
`define GLYPH_BLIT_PAGE_FRAMEBUFFER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GBPF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define GBPF_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `GBPF_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

FILE: rtl/core/gbpf_pkg.sv
// Package for the glyph blit page frame store: command codes, field widths,
// default screen size and the bit reversal used on read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbpf_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;

    localparam int CMD_W   = 2;
    localparam int COORD_W = 10;
    localparam int IDX_W   = 12;
    localparam int BYTE_W  = 8;
    localparam int FI_W    = 10;

    // Divider and address arithmetic widths.
    localparam int RH_W   = 7;
    localparam int REM_W  = 6;
    localparam int CNT_W  = 4;
    localparam int CHK_W  = 12;
    localparam int COL_W  = 14;
    localparam int PAGE_W = 8;
    localparam int POS_W  = 20;

    localparam logic [CMD_W-1:0] CMD_PLOT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    function automatic logic [BYTE_W-1:0] flip_bits(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        v = ((b & 8'hF0) >> 4) | ((b & 8'h0F) << 4);
        v = ((v & 8'hCC) >> 2) | ((v & 8'h33) << 2);
        v = ((v & 8'hAA) >> 1) | ((v & 8'h55) << 1);
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gbpf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the frame store.
`timescale 1ns / 1ps
`default_nettype none

module gbpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/glyph_blit_page_framebuffer.sv
// Top level of the glyph blit page frame store: command decode, plot address
// divider, read-modify-write sequencer. Depends on gbpf_pkg, gbpf_ram, macros.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+------------------------------------
//  in      | i_in_valid   | o_in_ready   | i_command, i_glyph_*, i_byte_index,
//          |              |              | i_glyph_byte, i_frame_index
//  out     | o_out_valid  | i_out_ready  | o_read_valid, o_read_data
//
// A plot runs the check, the bit-serial byte_index / raster height divider,
// address math and up to two read-modify-writes through the frame store.
// A rejected plot stops after the check; a clear zeroes one in-range entry,
// a read fetches one, and an unused command goes straight to the done state.
// After reset a clearing pass zeroes all SCREEN_WIDTH*SCREEN_HEIGHT/8 store
// entries (1024 by default), with o_in_ready low.
// A new transaction is accepted while a result waits in the output register;
// its own result then holds in the done state until the register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "glyph_blit_page_framebuffer_macros.svh"

module glyph_blit_page_framebuffer #(
    parameter int SCREEN_WIDTH  = gbpf_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = gbpf_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic        [gbpf_pkg::CMD_W-1:0]   i_command,
    input  wire logic signed [gbpf_pkg::COORD_W-1:0] i_glyph_x,
    input  wire logic signed [gbpf_pkg::COORD_W-1:0] i_glyph_y,
    input  wire logic signed [gbpf_pkg::COORD_W-1:0] i_glyph_width,
    input  wire logic signed [gbpf_pkg::COORD_W-1:0] i_glyph_height,
    input  wire logic        [gbpf_pkg::IDX_W-1:0]   i_byte_index,
    input  wire logic        [gbpf_pkg::BYTE_W-1:0]  i_glyph_byte,
    input  wire logic        [gbpf_pkg::FI_W-1:0]    i_frame_index,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_read_valid,
    output logic             [gbpf_pkg::BYTE_W-1:0]  o_read_data
);

    localparam int STORE = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
    localparam int AW    = $clog2(STORE);

    localparam int COORD_W = gbpf_pkg::COORD_W;
    localparam int IDX_W   = gbpf_pkg::IDX_W;
    localparam int BYTE_W  = gbpf_pkg::BYTE_W;
    localparam int FI_W    = gbpf_pkg::FI_W;
    localparam int RH_W    = gbpf_pkg::RH_W;
    localparam int REM_W   = gbpf_pkg::REM_W;
    localparam int CNT_W   = gbpf_pkg::CNT_W;
    localparam int CHK_W   = gbpf_pkg::CHK_W;
    localparam int COL_W   = gbpf_pkg::COL_W;
    localparam int PAGE_W  = gbpf_pkg::PAGE_W;
    localparam int POS_W   = gbpf_pkg::POS_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_POS   = 4'd4;
    localparam logic [3:0] S_ADDR  = 4'd5;
    localparam logic [3:0] S_RD0   = 4'd6;
    localparam logic [3:0] S_WR0   = 4'd7;
    localparam logic [3:0] S_WR1   = 4'd8;
    localparam logic [3:0] S_RDF   = 4'd9;
    localparam logic [3:0] S_RDW   = 4'd10;
    localparam logic [3:0] S_WIPE  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_w;
    logic signed [COORD_W-1:0] r_h;
    logic        [IDX_W-1:0]   r_idx;
    logic        [BYTE_W-1:0]  r_byte;
    logic        [FI_W-1:0]    r_fi;

    logic [AW-1:0]    r_clr_addr;
    logic [IDX_W-1:0] r_quo;
    logic [REM_W-1:0] r_rem;
    logic [RH_W-1:0]  r_rh;
    logic [CNT_W-1:0] r_cnt;

    logic signed [COL_W-1:0] r_col;
    logic signed [POS_W-1:0] r_prow;
    logic [AW-1:0]           r_addr;
    logic                    r_spill;

    logic              r_res_valid;
    logic [BYTE_W-1:0] r_res_data;

    logic              r_out_valid;
    logic              r_out_read_valid;
    logic [BYTE_W-1:0] r_out_read_data;

    logic              w_accept;
    logic              w_out_load;
    logic              w_fi_ok;
    logic              w_reject;
    logic [RH_W-1:0]   w_rh;
    logic [COORD_W-1:0] w_hm1;
    logic signed [CHK_W-1:0] w_x12;
    logic signed [CHK_W-1:0] w_y12;
    logic signed [CHK_W-1:0] w_w12;
    logic signed [CHK_W-1:0] w_h12;
    logic [RH_W-1:0]   w_trial;
    logic              w_ge;
    logic signed [COL_W-1:0]  w_col;
    logic signed [PAGE_W-1:0] w_page;
    logic signed [POS_W-1:0]  w_pos;
    logic              w_hit;
    logic [2:0]        w_yoff;
    logic [2*BYTE_W-1:0] w_shift;
    logic [AW-1:0]     w_below;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [BYTE_W-1:0] w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic [BYTE_W-1:0] w_rdata;

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid  = r_out_valid;
    assign o_read_valid = r_out_read_valid;
    assign o_read_data  = r_out_read_data;

    assign w_fi_ok = int'(r_fi) < STORE;

    // Rejection of glyphs with negative width, non-positive height or wholly off screen.
    assign w_x12 = CHK_W'(r_x);
    assign w_y12 = CHK_W'(r_y);
    assign w_w12 = CHK_W'(r_w);
    assign w_h12 = CHK_W'(r_h);
    assign w_reject = (r_w < 0) || (r_h <= 0)
                   || ((w_y12 + w_h12) < 0) || (w_y12 > CHK_W'(SCREEN_HEIGHT))
                   || ((w_x12 + w_w12) < 0) || (w_x12 > CHK_W'(SCREEN_WIDTH));
    assign w_hm1 = r_h - COORD_W'(1);
    assign w_rh  = {1'b0, w_hm1[8:3]} + RH_W'(1);

    // One restoring step of byte_index / raster height.
    assign w_trial = {r_rem, r_quo[IDX_W-1]};
    assign w_ge    = (w_trial >= r_rh);

    // Column, page row and entry address.
    assign w_col  = COL_W'(r_x) + $signed({2'b00, r_quo});
    assign w_page = PAGE_W'(r_y >>> 3) + $signed({2'b00, r_rem});
    assign w_pos  = POS_W'(r_col) + r_prow;
    assign w_hit  = (w_pos >= 0) && (w_pos < POS_W'(STORE))
                 && (r_col >= 0) && (r_col < COL_W'(SCREEN_WIDTH));

    assign w_yoff  = r_y[2:0];
    assign w_shift = (2*BYTE_W)'(r_byte) << w_yoff;
    assign w_below = r_addr + AW'(SCREEN_WIDTH);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(STORE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (i_command)
                        gbpf_pkg::CMD_PLOT:  n_state = S_CHECK;
                        gbpf_pkg::CMD_READ:  n_state = S_RDF;
                        gbpf_pkg::CMD_CLEAR: n_state = S_WIPE;
                        default:             n_state = S_DONE;
                    endcase
                end
            end
            S_CHECK: n_state = w_reject ? S_DONE : S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_W'(IDX_W - 1)) begin
                    n_state = S_POS;
                end
            end
            S_POS:   n_state = S_ADDR;
            S_ADDR:  n_state = w_hit ? S_RD0 : S_DONE;
            S_RD0:   n_state = S_WR0;
            S_WR0:   n_state = r_spill ? S_WR1 : S_DONE;
            S_WR1:   n_state = S_DONE;
            S_RDF:   n_state = S_RDW;
            S_RDW:   n_state = S_DONE;
            S_WIPE:  n_state = S_DONE;
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        w_re    = 1'b0;
        w_raddr = '0;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
            end
            S_WIPE: begin
                w_we    = w_fi_ok;
                w_waddr = AW'(r_fi);
            end
            S_RD0: begin
                w_re    = 1'b1;
                w_raddr = r_addr;
            end
            S_WR0: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wdata = w_rdata | w_shift[BYTE_W-1:0];
                w_re    = r_spill;
                w_raddr = w_below;
            end
            S_WR1: begin
                w_we    = 1'b1;
                w_waddr = w_below;
                w_wdata = w_rdata | w_shift[2*BYTE_W-1:BYTE_W];
            end
            S_RDF: begin
                w_re    = w_fi_ok;
                w_raddr = AW'(r_fi);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x         <= i_glyph_x;
            r_y         <= i_glyph_y;
            r_w         <= i_glyph_width;
            r_h         <= i_glyph_height;
            r_idx       <= i_byte_index;
            r_byte      <= i_glyph_byte;
            r_fi        <= i_frame_index;
            r_res_valid <= 1'b0;
            r_res_data  <= '0;
        end
        case (r_state)
            S_CHECK: begin
                r_quo <= r_idx;
                r_rem <= '0;
                r_rh  <= w_rh;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_quo <= {r_quo[IDX_W-2:0], w_ge};
                r_rem <= w_ge ? REM_W'(w_trial - r_rh) : w_trial[REM_W-1:0];
                r_cnt <= r_cnt + CNT_W'(1);
            end
            S_POS: begin
                r_col  <= w_col;
                r_prow <= POS_W'(w_page) * POS_W'(SCREEN_WIDTH);
            end
            S_ADDR: begin
                r_addr  <= AW'(w_pos);
                r_spill <= (w_pos < POS_W'(STORE - SCREEN_WIDTH));
            end
            S_RDW: begin
                r_res_valid <= 1'b1;
                r_res_data  <= w_fi_ok ? gbpf_pkg::flip_bits(w_rdata) : '0;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
        if (w_out_load) begin
            r_out_read_valid <= r_res_valid;
            r_out_read_data  <= r_res_data;
        end
    end

    gbpf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    `GBPF_ASSERT_NEVER(a_no_accept_in_clear, i_clk, i_rst_n, (r_state == S_CLEAR) && o_in_ready, "transaction accepted during clearing pass")
    `GBPF_ASSERT(a_div_bounded, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_cnt <= CNT_W'(IDX_W - 1)), "divider ran past its step count")
    `GBPF_ASSERT_NEVER(a_rw_collision, i_clk, i_rst_n, w_re && w_we && (w_raddr == w_waddr), "read and write to the same frame entry in one cycle")
    `GBPF_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state == S_DONE), "result raised outside the done state")

endmodule

`default_nettype wire

FILE: verif/gbpf_frame_checker.sv
// Scoreboard for the glyph blit page frame store: keeps a shadow of the frame
// store, predicts each readback and compares it with the output channel.
// Depends on gbpf_pkg for command codes and the default screen size.
`timescale 1ns / 1ps

module gbpf_frame_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic        [gbpf_pkg::CMD_W-1:0]      i_command,
    input  logic signed [gbpf_pkg::COORD_W-1:0]    i_glyph_x,
    input  logic signed [gbpf_pkg::COORD_W-1:0]    i_glyph_y,
    input  logic signed [gbpf_pkg::COORD_W-1:0]    i_glyph_width,
    input  logic signed [gbpf_pkg::COORD_W-1:0]    i_glyph_height,
    input  logic        [gbpf_pkg::IDX_W-1:0]      i_byte_index,
    input  logic        [gbpf_pkg::BYTE_W-1:0]     i_glyph_byte,
    input  logic        [gbpf_pkg::FI_W-1:0]       i_frame_index,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic                                   i_read_valid,
    input  logic        [gbpf_pkg::BYTE_W-1:0]     i_read_data,
    output int                                     o_fail_count,
    output int                                     o_pending
);

    localparam int SCREEN_W    = gbpf_pkg::SCREEN_WIDTH_DEF;
    localparam int SCREEN_H    = gbpf_pkg::SCREEN_HEIGHT_DEF;
    localparam int STORE_DEPTH = SCREEN_W * SCREEN_H / 8;

    typedef struct packed {
        logic                          valid;
        logic [gbpf_pkg::BYTE_W-1:0]   data;
    } t_readback;

    logic [7:0] shadow_pages [STORE_DEPTH];
    t_readback  readback_fifo [$];
    int         mismatches;

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            shadow_pages[i] = 8'h00;
        end
        mismatches = 0;
    end

    function automatic logic [7:0] mirror_byte(input logic [7:0] b);
        logic [7:0] m;
        for (int i = 0; i < 8; i++) begin
            m[i] = b[7 - i];
        end
        return m;
    endfunction

    task automatic blit_glyph_byte(input int x, input int y, input int w, input int h,
                                   input int idx, input logic [7:0] gbyte);
        int         rows;
        int         yoff;
        int         col;
        int         pos;
        logic [15:0] spread;
        if (w < 0 || h <= 0) return;
        if (y + h < 0 || y > SCREEN_H) return;
        if (x + w < 0 || x > SCREEN_W) return;
        rows   = 1 + (h - 1) / 8;
        yoff   = y & 7;
        col    = x + idx / rows;
        pos    = col + ((y - yoff) / 8 + idx % rows) * SCREEN_W;
        if (pos < 0 || pos >= STORE_DEPTH || col < 0 || col >= SCREEN_W) return;
        spread = {8'h00, gbyte} << yoff;
        shadow_pages[pos] = shadow_pages[pos] | spread[7:0];
        if (pos < STORE_DEPTH - SCREEN_W) begin
            shadow_pages[pos + SCREEN_W] = shadow_pages[pos + SCREEN_W] | spread[15:8];
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_readback want;
        t_readback got;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                want = '0;
                case (i_command)
                    gbpf_pkg::CMD_PLOT: begin
                        blit_glyph_byte(int'(i_glyph_x), int'(i_glyph_y),
                                        int'(i_glyph_width), int'(i_glyph_height),
                                        int'(i_byte_index), i_glyph_byte);
                    end
                    gbpf_pkg::CMD_READ: begin
                        want.valid = 1'b1;
                        if (int'(i_frame_index) < STORE_DEPTH) begin
                            want.data = mirror_byte(shadow_pages[i_frame_index]);
                        end
                    end
                    gbpf_pkg::CMD_CLEAR: begin
                        if (int'(i_frame_index) < STORE_DEPTH) begin
                            shadow_pages[i_frame_index] = 8'h00;
                        end
                    end
                    default: ;
                endcase
                readback_fifo.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got.valid = i_read_valid;
                got.data  = i_read_data;
                if (readback_fifo.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual valid=%0b data=%02h",
                             $time, got.valid, got.data);
                end else begin
                    want = readback_fifo.pop_front();
                    if (got.valid !== want.valid) begin
                        mismatches++;
                        $display("%0t: read_valid mismatch, expected %0b, actual %0b",
                                 $time, want.valid, got.valid);
                    end
                    if (got.data !== want.data) begin
                        mismatches++;
                        $display("%0t: read_data mismatch, expected %02h, actual %02h",
                                 $time, want.data, got.data);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= readback_fifo.size();
    end

endmodule

FILE: verif/tb_glyph_blit_page_framebuffer.sv
// Testbench top for glyph_blit_page_framebuffer: drives plot, read and clear
// transactions under several flow-control phases and reports the verdict.
// Depends on gbpf_pkg, the block RTL and gbpf_frame_checker.
`timescale 1ns / 1ps

module tb_glyph_blit_page_framebuffer;

    localparam logic [gbpf_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                                 i_clk          = 1'b0;
    logic                                 i_rst_n        = 1'b0;
    logic                                 i_in_valid     = 1'b0;
    logic        [gbpf_pkg::CMD_W-1:0]    i_command      = gbpf_pkg::CMD_PLOT;
    logic signed [gbpf_pkg::COORD_W-1:0]  i_glyph_x      = '0;
    logic signed [gbpf_pkg::COORD_W-1:0]  i_glyph_y      = '0;
    logic signed [gbpf_pkg::COORD_W-1:0]  i_glyph_width  = '0;
    logic signed [gbpf_pkg::COORD_W-1:0]  i_glyph_height = '0;
    logic        [gbpf_pkg::IDX_W-1:0]    i_byte_index   = '0;
    logic        [gbpf_pkg::BYTE_W-1:0]   i_glyph_byte   = '0;
    logic        [gbpf_pkg::FI_W-1:0]     i_frame_index  = '0;
    logic                                 i_out_ready    = 1'b0;
    logic                                 o_in_ready;
    logic                                 o_out_valid;
    logic                                 o_read_valid;
    logic        [gbpf_pkg::BYTE_W-1:0]   o_read_data;

    int fail_count;
    int pending;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int plots_sent         = 0;
    int reads_sent         = 0;
    int clears_sent        = 0;
    int unused_sent        = 0;
    int recent_x           = 0;
    int recent_y           = 0;

    glyph_blit_page_framebuffer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_glyph_x      (i_glyph_x),
        .i_glyph_y      (i_glyph_y),
        .i_glyph_width  (i_glyph_width),
        .i_glyph_height (i_glyph_height),
        .i_byte_index   (i_byte_index),
        .i_glyph_byte   (i_glyph_byte),
        .i_frame_index  (i_frame_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_valid   (o_read_valid),
        .o_read_data    (o_read_data)
    );

    gbpf_frame_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_glyph_x      (i_glyph_x),
        .i_glyph_y      (i_glyph_y),
        .i_glyph_width  (i_glyph_width),
        .i_glyph_height (i_glyph_height),
        .i_byte_index   (i_byte_index),
        .i_glyph_byte   (i_glyph_byte),
        .i_frame_index  (i_frame_index),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_read_valid   (o_read_valid),
        .i_read_data    (o_read_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    task automatic issue(input logic [1:0] cmd, input int x, input int y, input int w,
                         input int h, input int idx, input int gbyte, input int fi);
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_glyph_x      <= x[9:0];
        i_glyph_y      <= y[9:0];
        i_glyph_width  <= w[9:0];
        i_glyph_height <= h[9:0];
        i_byte_index   <= idx[11:0];
        i_glyph_byte   <= gbyte[7:0];
        i_frame_index  <= fi[9:0];
        do @(posedge i_clk); while (!o_in_ready);
        case (cmd)
            gbpf_pkg::CMD_PLOT:  plots_sent++;
            gbpf_pkg::CMD_READ:  reads_sent++;
            gbpf_pkg::CMD_CLEAR: clears_sent++;
            default:             unused_sent++;
        endcase
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every readback has drained.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic int near_index();
        int col;
        int page;
        col  = (recent_x + int'($urandom_range(0, 7))) & 127;
        page = ((recent_y >>> 3) + int'($urandom_range(0, 1))) & 7;
        return page * 128 + col;
    endfunction

    task automatic issue_random();
        int pick;
        int w;
        int h;
        int rows;
        int fi;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            w        = $urandom_range(1, 20);
            h        = $urandom_range(1, 24);
            rows     = 1 + (h - 1) / 8;
            recent_x = int'($urandom_range(0, 135)) - 6;
            recent_y = int'($urandom_range(0, 70)) - 6;
            issue(gbpf_pkg::CMD_PLOT, recent_x, recent_y, w, h,
                  $urandom_range(0, w * rows - 1), $urandom_range(0, 255),
                  $urandom_range(0, 1023));
        end else if (pick < 90) begin
            fi = $urandom_range(0, 1) ? near_index() : int'($urandom_range(0, 1023));
            issue(pick < 75 ? gbpf_pkg::CMD_READ : gbpf_pkg::CMD_CLEAR,
                  $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 4095), $urandom_range(0, 255), fi);
        end else begin
            issue(gbpf_pkg::CMD_W'($urandom_range(0, 3)),
                  $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 4095), $urandom_range(0, 255), $urandom_range(0, 1023));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(gbpf_pkg::CMD_READ,  0, 0, 0, 0, 0, 0, 0);
        issue(gbpf_pkg::CMD_PLOT,  0, 0, 1, 8, 0, 8'h0F, 0);
        issue(gbpf_pkg::CMD_READ,  0, 0, 0, 0, 0, 0, 0);
        issue(gbpf_pkg::CMD_PLOT,  5, 3, 4, 8, 0, 8'hFF, 0);
        issue(gbpf_pkg::CMD_READ,  0, 0, 0, 0, 0, 0, 5);
        issue(gbpf_pkg::CMD_READ,  0, 0, 0, 0, 0, 0, 133);
        issue(gbpf_pkg::CMD_PLOT,  127, 61, 1, 3, 0, 8'hA5, 0);
        issue(gbpf_pkg::CMD_READ,  0, 0, 0, 0, 0, 0, 1023);
        issue(gbpf_pkg::CMD_PLOT,  -3, -5, 4, 10, 7, 8'hC3, 0);
        issue(gbpf_pkg::CMD_PLOT,  -3, -5, 4, 10, 6, 8'hFF, 0);
        issue(gbpf_pkg::CMD_PLOT,  -3, -5, 4, 10, 5, 8'hFF, 0);
        issue(gbpf_pkg::CMD_READ,  0, 0, 0, 0, 0, 0, 128);
        issue(gbpf_pkg::CMD_PLOT,  10, 10, -1, 8, 0, 8'hFF, 0);
        issue(gbpf_pkg::CMD_PLOT,  10, 10, 4, 0, 0, 8'hFF, 0);
        issue(gbpf_pkg::CMD_PLOT,  10, -20, 4, 10, 0, 8'hFF, 0);
        issue(gbpf_pkg::CMD_PLOT,  10, 65, 4, -512, 0, 8'hFF, 0);
        issue(gbpf_pkg::CMD_PLOT,  129, 10, 4, 8, 0, 8'hFF, 0);
        issue(gbpf_pkg::CMD_PLOT,  -10, 10, 5, 8, 0, 8'hFF, 0);
        issue(gbpf_pkg::CMD_PLOT,  511, -512, 511, 511, 4095, 8'hFF, 1023);
        issue(gbpf_pkg::CMD_PLOT,  -60, -300, 511, 511, 4095, 8'h00, 0);
        issue(gbpf_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 5);
        issue(gbpf_pkg::CMD_READ,  0, 0, 0, 0, 0, 0, 5);
        issue(gbpf_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 1023);
        issue(gbpf_pkg::CMD_READ,  0, 0, 0, 0, 0, 0, 1023);
        issue(CMD_UNUSED, -1, -1, -1, -1, 4095, 8'hFF, 1023);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct    = (phase == 1) ? 50 : (phase == 3) ? 38 : 0;
            receiver_stall_pct = (phase == 2) ? 50 : (phase == 3) ? 38 : 0;
            for (int k = 0; k < 238; k++) begin
                issue_random();
                if (k == 119) begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        $display("Covered %0d plots, %0d reads, %0d clears and %0d unused commands",
                 plots_sent, reads_sent, clears_sent, unused_sent);
        $display("across free-running, sender-idle, receiver-stall and mixed flow phases");
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/gbpf_pkg.sv
rtl/core/gbpf_ram.sv
rtl/core/glyph_blit_page_framebuffer.sv
verif/gbpf_frame_checker.sv
verif/tb_glyph_blit_page_framebuffer.sv
